FILE: sv/lth_pkg.sv
// Package for the line triangle hit test block.
// Holds the default coordinate width and the configuration register indexes.
// No dependencies; used by line_triangle_hit_test_top.
package lth_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_ORIGIN_Z  = 3'd2,
        REG_HEADING_X = 3'd3,
        REG_HEADING_Y = 3'd4,
        REG_HEADING_Z = 3'd5
    } cfg_reg_t;

endpackage

FILE: sv/lth_cross.sv
// Registered cross product of two signed vectors.
// Stand-alone arithmetic stage; depends on nothing else in the project.
module lth_cross #(
    parameter int W_IN = 17
) (
    input  logic                     clk,
    input  logic signed [W_IN-1:0]   a_x,
    input  logic signed [W_IN-1:0]   a_y,
    input  logic signed [W_IN-1:0]   a_z,
    input  logic signed [W_IN-1:0]   b_x,
    input  logic signed [W_IN-1:0]   b_y,
    input  logic signed [W_IN-1:0]   b_z,
    output logic signed [2*W_IN:0]   c_x,
    output logic signed [2*W_IN:0]   c_y,
    output logic signed [2*W_IN:0]   c_z
);

    localparam int OW = 2 * W_IN + 1;

    logic signed [OW-1:0] ax_e, ay_e, az_e, bx_e, by_e, bz_e;
    logic signed [OW-1:0] c_x_next, c_y_next, c_z_next;
    logic signed [OW-1:0] c_x_reg, c_y_reg, c_z_reg;

    assign ax_e = {{(OW-W_IN){a_x[W_IN-1]}}, a_x};
    assign ay_e = {{(OW-W_IN){a_y[W_IN-1]}}, a_y};
    assign az_e = {{(OW-W_IN){a_z[W_IN-1]}}, a_z};
    assign bx_e = {{(OW-W_IN){b_x[W_IN-1]}}, b_x};
    assign by_e = {{(OW-W_IN){b_y[W_IN-1]}}, b_y};
    assign bz_e = {{(OW-W_IN){b_z[W_IN-1]}}, b_z};

    // Each product fits in 2*W_IN bits, so the difference fits in OW bits.
    always_comb
    begin
        c_x_next = ay_e * bz_e - az_e * by_e;
        c_y_next = az_e * bx_e - ax_e * bz_e;
        c_z_next = ax_e * by_e - ay_e * bx_e;
    end

    always_ff @(posedge clk)
    begin
        c_x_reg <= c_x_next;
        c_y_reg <= c_y_next;
        c_z_reg <= c_z_next;
    end

    assign c_x = c_x_reg;
    assign c_y = c_y_reg;
    assign c_z = c_z_reg;

endmodule

FILE: sv/line_triangle_hit_test_top.sv
// Line triangle hit test: one fixed line against a stream of triangles.
// An accepted triangle travels through the registers of every stage, and
// its result strobe comes from the last of them. Throughput is one triangle
// per cycle; busy stays low, since the five-stage pipeline never stalls.
// Reset (rst_n low, asynchronous) clears the line registers to zero and
// empties the pipeline. Depends on lth_pkg and lth_cross.
module line_triangle_hit_test_top #(
    parameter int COORD_BITS = lth_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [COORD_BITS-1:0]         vert_a_x,
    input  logic signed [COORD_BITS-1:0]         vert_a_y,
    input  logic signed [COORD_BITS-1:0]         vert_a_z,
    input  logic signed [COORD_BITS-1:0]         vert_b_x,
    input  logic signed [COORD_BITS-1:0]         vert_b_y,
    input  logic signed [COORD_BITS-1:0]         vert_b_z,
    input  logic signed [COORD_BITS-1:0]         vert_c_x,
    input  logic signed [COORD_BITS-1:0]         vert_c_y,
    input  logic signed [COORD_BITS-1:0]         vert_c_z,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lth_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic signed [COORD_BITS-1:0]         cfg_data,
    output logic                                 result_valid,
    output logic                                 hit
);

    // The test uses the identity that the barycentric coordinate of the
    // crossing point for vertex A, scaled by den = H.N, equals the scalar
    // triple product [H, B-O, C-O] (likewise for B with [H, C-O, A-O]).
    // The three scaled coordinates sum to den, so the one for C is
    // den minus the other two. Barycentric coordinates are unchanged by the
    // xy projection whenever the projected area N.z is nonzero, so this
    // matches the projected form exactly; a zero N.z is still a miss.
    //
    // Stage 1: edge vectors and vertex offsets from the origin.
    // Stage 2: three cross products (normal and two offset crosses).
    // Stage 3: nine products of heading components with those crosses.
    // Stage 4: three dot-product sums.
    // Stage 5: unit-interval tests and the registered hit flag.

    localparam int W  = COORD_BITS;
    localparam int DW = W + 1;          // differences of two coordinates
    localparam int CW = 2 * DW + 1;     // cross product components
    localparam int PW = W + CW;         // heading times a cross component
    localparam int KW = PW + 2;         // sum of three such products
    localparam int MW = KW + 2;         // room for den minus two terms

    // ------------------------------------------------------------------
    // Configuration registers. The port is always ready; the user must write them
    // only while the pipeline is empty: the block itself does not enforce this.
    // ------------------------------------------------------------------
    logic signed [W-1:0] org_x_reg, org_y_reg, org_z_reg;
    logic signed [W-1:0] hd_x_reg, hd_y_reg, hd_z_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
            hd_x_reg  <= '0;
            hd_y_reg  <= '0;
            hd_z_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lth_pkg::cfg_reg_t'(cfg_index))
                lth_pkg::REG_ORIGIN_X:  org_x_reg <= cfg_data;
                lth_pkg::REG_ORIGIN_Y:  org_y_reg <= cfg_data;
                lth_pkg::REG_ORIGIN_Z:  org_z_reg <= cfg_data;
                lth_pkg::REG_HEADING_X: hd_x_reg  <= cfg_data;
                lth_pkg::REG_HEADING_Y: hd_y_reg  <= cfg_data;
                lth_pkg::REG_HEADING_Z: hd_z_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid bits that travel with each triangle.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic accept;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: differences, each one bit wider than a coordinate.
    // ------------------------------------------------------------------
    logic signed [DW-1:0] ax_e, ay_e, az_e, bx_e, by_e, bz_e, cx_e, cy_e, cz_e;
    logic signed [DW-1:0] ox_e, oy_e, oz_e;
    logic signed [DW-1:0] e1_x_reg, e1_y_reg, e1_z_reg, e2_x_reg, e2_y_reg, e2_z_reg;
    logic signed [DW-1:0] bo_x_reg, bo_y_reg, bo_z_reg, co_x_reg, co_y_reg, co_z_reg;
    logic signed [DW-1:0] ao_x_reg, ao_y_reg, ao_z_reg;

    assign ax_e = {vert_a_x[W-1], vert_a_x};
    assign ay_e = {vert_a_y[W-1], vert_a_y};
    assign az_e = {vert_a_z[W-1], vert_a_z};
    assign bx_e = {vert_b_x[W-1], vert_b_x};
    assign by_e = {vert_b_y[W-1], vert_b_y};
    assign bz_e = {vert_b_z[W-1], vert_b_z};
    assign cx_e = {vert_c_x[W-1], vert_c_x};
    assign cy_e = {vert_c_y[W-1], vert_c_y};
    assign cz_e = {vert_c_z[W-1], vert_c_z};
    assign ox_e = {org_x_reg[W-1], org_x_reg};
    assign oy_e = {org_y_reg[W-1], org_y_reg};
    assign oz_e = {org_z_reg[W-1], org_z_reg};

    always_ff @(posedge clk)
    begin
        e1_x_reg <= bx_e - ax_e;
        e1_y_reg <= by_e - ay_e;
        e1_z_reg <= bz_e - az_e;
        e2_x_reg <= cx_e - ax_e;
        e2_y_reg <= cy_e - ay_e;
        e2_z_reg <= cz_e - az_e;
        bo_x_reg <= bx_e - ox_e;
        bo_y_reg <= by_e - oy_e;
        bo_z_reg <= bz_e - oz_e;
        co_x_reg <= cx_e - ox_e;
        co_y_reg <= cy_e - oy_e;
        co_z_reg <= cz_e - oz_e;
        ao_x_reg <= ax_e - ox_e;
        ao_y_reg <= ay_e - oy_e;
        ao_z_reg <= az_e - oz_e;
    end

    // ------------------------------------------------------------------
    // Stage 2: the plane normal and the two offset cross products.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] n_x, n_y, n_z;
    logic signed [CW-1:0] qa_x, qa_y, qa_z;
    logic signed [CW-1:0] qb_x, qb_y, qb_z;

    lth_cross #(.W_IN(DW)) u_cross_n (
        .clk (clk),
        .a_x (e1_x_reg), .a_y (e1_y_reg), .a_z (e1_z_reg),
        .b_x (e2_x_reg), .b_y (e2_y_reg), .b_z (e2_z_reg),
        .c_x (n_x), .c_y (n_y), .c_z (n_z)
    );

    lth_cross #(.W_IN(DW)) u_cross_a (
        .clk (clk),
        .a_x (bo_x_reg), .a_y (bo_y_reg), .a_z (bo_z_reg),
        .b_x (co_x_reg), .b_y (co_y_reg), .b_z (co_z_reg),
        .c_x (qa_x), .c_y (qa_y), .c_z (qa_z)
    );

    lth_cross #(.W_IN(DW)) u_cross_b (
        .clk (clk),
        .a_x (co_x_reg), .a_y (co_y_reg), .a_z (co_z_reg),
        .b_x (ao_x_reg), .b_y (ao_y_reg), .b_z (ao_z_reg),
        .c_x (qb_x), .c_y (qb_y), .c_z (qb_z)
    );

    // ------------------------------------------------------------------
    // Stage 3: heading components times the cross components.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] hx_p, hy_p, hz_p;
    logic signed [PW-1:0] pn_x_reg, pn_y_reg, pn_z_reg;
    logic signed [PW-1:0] pa_x_reg, pa_y_reg, pa_z_reg;
    logic signed [PW-1:0] pb_x_reg, pb_y_reg, pb_z_reg;
    logic                 nz_zero3_reg;

    assign hx_p = {{(PW-W){hd_x_reg[W-1]}}, hd_x_reg};
    assign hy_p = {{(PW-W){hd_y_reg[W-1]}}, hd_y_reg};
    assign hz_p = {{(PW-W){hd_z_reg[W-1]}}, hd_z_reg};

    function automatic logic signed [PW-1:0] ext_c(input logic signed [CW-1:0] v);
        ext_c = {{(PW-CW){v[CW-1]}}, v};
    endfunction

    always_ff @(posedge clk)
    begin
        pn_x_reg     <= hx_p * ext_c(n_x);
        pn_y_reg     <= hy_p * ext_c(n_y);
        pn_z_reg     <= hz_p * ext_c(n_z);
        pa_x_reg     <= hx_p * ext_c(qa_x);
        pa_y_reg     <= hy_p * ext_c(qa_y);
        pa_z_reg     <= hz_p * ext_c(qa_z);
        pb_x_reg     <= hx_p * ext_c(qb_x);
        pb_y_reg     <= hy_p * ext_c(qb_y);
        pb_z_reg     <= hz_p * ext_c(qb_z);
        nz_zero3_reg <= (n_z == '0);
    end

    // ------------------------------------------------------------------
    // Stage 4: dot-product sums. den is H.N; ka and kb are the scaled
    // barycentric coordinates of vertices A and B.
    // ------------------------------------------------------------------
    logic signed [KW-1:0] den_reg, ka_reg, kb_reg;
    logic                 nz_zero4_reg;

    function automatic logic signed [KW-1:0] ext_p(input logic signed [PW-1:0] v);
        ext_p = {{(KW-PW){v[PW-1]}}, v};
    endfunction

    always_ff @(posedge clk)
    begin
        den_reg      <= ext_p(pn_x_reg) + ext_p(pn_y_reg) + ext_p(pn_z_reg);
        ka_reg       <= ext_p(pa_x_reg) + ext_p(pa_y_reg) + ext_p(pa_z_reg);
        kb_reg       <= ext_p(pb_x_reg) + ext_p(pb_y_reg) + ext_p(pb_z_reg);
        nz_zero4_reg <= nz_zero3_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: each scaled coordinate k must satisfy 0 <= k/den <= 1.
    // For positive den that is k >= 0 and den - k >= 0; for negative den
    // it is k <= 0 and den - k <= 0.
    // ------------------------------------------------------------------
    logic signed [MW-1:0] den_m, ka_m, kb_m, kc_m;
    logic signed [MW-1:0] da_m, db_m, dc_m;
    logic                 den_neg, den_zero;
    logic                 ok_a, ok_b, ok_c;
    logic                 hit_next, hit_reg;

    function automatic logic signed [MW-1:0] ext_k(input logic signed [KW-1:0] v);
        ext_k = {{(MW-KW){v[KW-1]}}, v};
    endfunction

    function automatic logic unit_ok(
        input logic                  neg_den,
        input logic signed [MW-1:0]  k,
        input logic signed [MW-1:0]  d
    );
        if (!neg_den)
            unit_ok = !k[MW-1] && !d[MW-1];
        else
            unit_ok = (k[MW-1] || (k == '0)) && (d[MW-1] || (d == '0));
    endfunction

    always_comb
    begin
        den_m    = ext_k(den_reg);
        ka_m     = ext_k(ka_reg);
        kb_m     = ext_k(kb_reg);
        kc_m     = den_m - ka_m - kb_m;
        da_m     = den_m - ka_m;
        db_m     = den_m - kb_m;
        dc_m     = den_m - kc_m;
        den_neg  = den_reg[KW-1];
        den_zero = (den_reg == '0);
        ok_a     = unit_ok(den_neg, ka_m, da_m);
        ok_b     = unit_ok(den_neg, kb_m, db_m);
        ok_c     = unit_ok(den_neg, kc_m, dc_m);
        hit_next = !den_zero && !nz_zero4_reg && ok_a && ok_b && ok_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else
            hit_reg <= hit_next && v4_reg;
    end

    assign result_valid = v5_reg;
    assign hit          = hit_reg;

endmodule

FILE: sv/lth_checker.sv
// Port-level checker for the line triangle hit test block, bound to the top.
// Depends on line_triangle_hit_test_top and its port names.
module lth_port_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input logic hit
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy rose although the pipeline never stalls");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 result_valid)
        else $error("accepted transaction produced no result after five cycles");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, 5))
        else $error("result strobe without a matching accepted transaction");

    a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !hit)
        else $error("hit high outside a result strobe");

endmodule

bind line_triangle_hit_test_top lth_port_checker u_lth_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .hit          (hit)
);
